### hw/rtl/qrot_pkg.sv
package qrot_pkg;

   // magnitudes are prescaled so the largest one has its top bit here
   localparam int PRESCALE_TOP = 29;
   localparam int A_W = PRESCALE_TOP + 1;
   localparam int S2_W = 2 * A_W + 2;
   localparam int ROOT_W = S2_W / 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int CFG_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_MIN_NORM_SQUARED = 0;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic int nfrac(input int vec_w);
      return ((61 - vec_w) < 30) ? (61 - vec_w) : 30;
   endfunction

endpackage

### hw/rtl/qrot_front.sv
module qrot_front #(
   parameter int QUAT_WIDTH = 16,
   parameter int VEC_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   in_valid,
   input  logic [4*QUAT_WIDTH+3*VEC_WIDTH-1:0]    in_data,
   input  logic [qrot_pkg::CFG_W-1:0]             min_norm,
   output logic                                   out_valid,
   output logic [3*VEC_WIDTH+5+4*qrot_pkg::A_W+qrot_pkg::S2_W-1:0] out_entry
);

   localparam int QW = QUAT_WIDTH;
   localparam int VW = VEC_WIDTH;
   localparam int LW = $clog2(QW);
   localparam int SQ_W = 2 * QW;
   localparam int SUM_W = 2 * QW + 2;
   localparam int PT = qrot_pkg::PRESCALE_TOP;
   localparam int AW = qrot_pkg::A_W;
   localparam int WIDE_W = QW + PT;
   localparam int S2W = qrot_pkg::S2_W;

   // stage 1: signs and magnitudes
   logic              v1_ff;
   logic [3:0]        sign1_ff, sign1_in;
   logic [QW-1:0]     abs1_ff [4];
   logic [QW-1:0]     abs1_in [4];
   logic [3*VW-1:0]   vec1_ff;

   // stage 2: raw squares and leading one
   logic              v2_ff;
   logic [3:0]        sign2_ff;
   logic [QW-1:0]     abs2_ff [4];
   logic [SQ_W-1:0]   sq2_ff [4];
   logic [SQ_W-1:0]   sq2_in [4];
   logic [LW-1:0]     lead2_ff, lead2_in;
   logic [3*VW-1:0]   vec2_ff;

   // stage 3: singular test and prescale
   logic              v3_ff;
   logic [3:0]        sign3_ff;
   logic              sing3_ff, sing3_in;
   logic [AW-1:0]     pre3_ff [4];
   logic [AW-1:0]     pre3_in [4];
   logic [3*VW-1:0]   vec3_ff;

   // stage 4: prescaled squares
   logic              v4_ff;
   logic [3:0]        sign4_ff;
   logic              sing4_ff;
   logic [AW-1:0]     pre4_ff [4];
   logic [2*AW-1:0]   sq4_ff [4];
   logic [3*VW-1:0]   vec4_ff;

   logic [QW-1:0]     orm;
   logic [SUM_W-1:0]  sum;
   logic [WIDE_W-1:0] wide;
   logic [S2W-1:0]    s2;
   logic [QW-1:0]     q;

   always_comb begin
      q = '0;
      for (int i = 0; i < 4; i++) begin
         q = in_data[i*QW +: QW];
         sign1_in[i] = q[QW-1];
         abs1_in[i] = q[QW-1] ? (~q + QW'(1)) : q;
      end
   end

   always_comb begin
      orm = abs1_ff[0] | abs1_ff[1] | abs1_ff[2] | abs1_ff[3];
      lead2_in = '0;
      for (int j = 0; j < QW; j++) begin
         if (orm[j]) lead2_in = LW'(j);
      end
      for (int i = 0; i < 4; i++) begin
         sq2_in[i] = SQ_W'(abs1_ff[i]) * SQ_W'(abs1_ff[i]);
      end
   end

   always_comb begin
      sum = '0;
      wide = '0;
      for (int i = 0; i < 4; i++) begin
         sum = sum + SUM_W'(sq2_ff[i]);
      end
      sing3_in = (sum <= SUM_W'(min_norm));
      for (int i = 0; i < 4; i++) begin
         wide = WIDE_W'(abs2_ff[i]);
         if (int'(lead2_ff) < PT) begin
            wide = wide << (PT - int'(lead2_ff));
         end else begin
            wide = wide >> (int'(lead2_ff) - PT);
         end
         pre3_in[i] = wide[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sign1_ff <= sign1_in;
         vec1_ff <= in_data[4*QW +: 3*VW];
         sign2_ff <= sign1_ff;
         vec2_ff <= vec1_ff;
         lead2_ff <= lead2_in;
         sign3_ff <= sign2_ff;
         vec3_ff <= vec2_ff;
         sing3_ff <= sing3_in;
         sign4_ff <= sign3_ff;
         vec4_ff <= vec3_ff;
         sing4_ff <= sing3_ff;
         for (int i = 0; i < 4; i++) begin
            abs1_ff[i] <= abs1_in[i];
            abs2_ff[i] <= abs1_ff[i];
            sq2_ff[i] <= sq2_in[i];
            pre3_ff[i] <= pre3_in[i];
            pre4_ff[i] <= pre3_ff[i];
            sq4_ff[i] <= pre3_ff[i] * pre3_ff[i];
         end
      end
   end

   assign s2 = S2W'(sq4_ff[0]) + S2W'(sq4_ff[1]) + S2W'(sq4_ff[2]) + S2W'(sq4_ff[3]);
   assign out_valid = v4_ff;
   assign out_entry = {sing4_ff, sign4_ff, pre4_ff[3], pre4_ff[2], pre4_ff[1], pre4_ff[0],
                       s2, vec4_ff};

endmodule

### hw/rtl/qrot_queue.sv
module qrot_queue #(
   parameter int WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output qrot_pkg::qstat_type   status
);

   localparam int DEPTH = qrot_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CW'(1);
      else if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PW'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign status.full = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

### hw/rtl/qrot_back.sv
module qrot_back #(
   parameter int VEC_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [3*VEC_WIDTH+5+4*qrot_pkg::A_W+qrot_pkg::S2_W-1:0] in_entry,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [3*VEC_WIDTH-1:0] out_rot,
   output logic                   out_status,
   output logic                   out_saturated
);

   localparam int VW = VEC_WIDTH;
   localparam int AW = qrot_pkg::A_W;
   localparam int S2W = qrot_pkg::S2_W;
   localparam int RW = qrot_pkg::ROOT_W;
   localparam int REM_W = S2W + 1;
   localparam int NF = qrot_pkg::nfrac(VEC_WIDTH);
   localparam int DS = NF + 1;
   localparam int DW = NF + RW + 1;
   localparam int TW = 3 * VW + 5;
   localparam int NW = NF + 2;
   localparam int P1W = NW + VW;
   localparam int CW = VW + 3;
   localparam int P2W = NW + CW;
   localparam int ACW = P2W + 2;
   localparam int RDW = ACW - NF + 2;

   localparam logic signed [P1W:0] HALF1 = (P1W + 1)'(1) << (NF - 1);
   localparam logic signed [ACW-1:0] HALF2 = ACW'(1) << (NF - 2);
   localparam logic signed [RDW-1:0] VMAX = {{(RDW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
   localparam logic signed [RDW-1:0] VMIN = {{(RDW - VW + 1){1'b1}}, {(VW - 1){1'b0}}};

   logic en;
   logic out_valid_ff;

   assign en = !out_valid_ff || out_ready;
   assign pop = en && in_valid;

   logic [TW-1:0]   ent_tail;
   logic [S2W-1:0]  ent_s2;
   logic [4*AW-1:0] ent_pre;

   assign ent_tail = {in_entry[3*VW+S2W+4*AW +: 5], in_entry[3*VW-1:0]};
   assign ent_s2 = in_entry[3*VW +: S2W];
   assign ent_pre = in_entry[3*VW+S2W +: 4*AW];

   // square root, one root bit per stage
   logic [REM_W-1:0] sq_rem_ff [RW];
   logic [RW-1:0]    sq_root_ff [RW];
   logic [4*AW-1:0]  sq_pre_ff [RW];
   logic [TW-1:0]    sq_tail_ff [RW];
   logic [RW-1:0]    sq_v_ff;

   for (genvar k = 0; k < RW; k++) begin : g_sq
      localparam int BIT = RW - 1 - k;
      logic [REM_W-1:0] rem_prev, trial, rem_in;
      logic [RW-1:0]    root_prev, root_in;
      logic [4*AW-1:0]  pre_prev;
      logic [TW-1:0]    tail_prev;
      logic             v_prev;

      if (k == 0) begin : g_first
         assign rem_prev = REM_W'(ent_s2);
         assign root_prev = '0;
         assign pre_prev = ent_pre;
         assign tail_prev = ent_tail;
         assign v_prev = pop;
      end else begin : g_next
         assign rem_prev = sq_rem_ff[k-1];
         assign root_prev = sq_root_ff[k-1];
         assign pre_prev = sq_pre_ff[k-1];
         assign tail_prev = sq_tail_ff[k-1];
         assign v_prev = sq_v_ff[k-1];
      end

      always_comb begin
         trial = (REM_W'(root_prev) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
         rem_in = rem_prev;
         root_in = root_prev;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            root_in = root_prev | (RW'(1) << BIT);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (en) begin
            sq_v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k] <= rem_in;
            sq_root_ff[k] <= root_in;
            sq_pre_ff[k] <= pre_prev;
            sq_tail_ff[k] <= tail_prev;
         end
      end
   end

   // four restoring dividers side by side, one quotient bit per stage
   logic [DW-1:0] dv_rem_ff [DS][4];
   logic [NF:0]   dv_q_ff [DS][4];
   logic [RW-1:0] dv_root_ff [DS];
   logic [TW-1:0] dv_tail_ff [DS];
   logic [DS-1:0] dv_v_ff;

   for (genvar k = 0; k < DS; k++) begin : g_dv
      localparam int BIT = NF - k;
      logic [DW-1:0] rem_prev [4];
      logic [NF:0]   q_prev [4];
      logic [DW-1:0] rem_in [4];
      logic [NF:0]   q_in [4];
      logic [DW-1:0] trial;
      logic [RW-1:0] root_prev;
      logic [TW-1:0] tail_prev;
      logic          v_prev;

      if (k == 0) begin : g_first
         assign root_prev = sq_root_ff[RW-1];
         assign tail_prev = sq_tail_ff[RW-1];
         assign v_prev = sq_v_ff[RW-1];
         for (genvar j = 0; j < 4; j++) begin : g_num
            // rounding term is half the norm
            assign rem_prev[j] = (DW'(sq_pre_ff[RW-1][j*AW +: AW]) << NF)
                               + DW'(sq_root_ff[RW-1] >> 1);
            assign q_prev[j] = '0;
         end
      end else begin : g_next
         assign root_prev = dv_root_ff[k-1];
         assign tail_prev = dv_tail_ff[k-1];
         assign v_prev = dv_v_ff[k-1];
         for (genvar j = 0; j < 4; j++) begin : g_cp
            assign rem_prev[j] = dv_rem_ff[k-1][j];
            assign q_prev[j] = dv_q_ff[k-1][j];
         end
      end

      always_comb begin
         trial = DW'(root_prev) << BIT;
         for (int j = 0; j < 4; j++) begin
            rem_in[j] = rem_prev[j];
            q_in[j] = q_prev[j];
            if (rem_prev[j] >= trial) begin
               rem_in[j] = rem_prev[j] - trial;
               q_in[j] = q_prev[j] | ((NF + 1)'(1) << BIT);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (en) begin
            dv_v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_root_ff[k] <= root_prev;
            dv_tail_ff[k] <= tail_prev;
            for (int j = 0; j < 4; j++) begin
               dv_rem_ff[k][j] <= rem_in[j];
               dv_q_ff[k][j] <= q_in[j];
            end
         end
      end
   end

   // rotation datapath
   logic signed [NW-1:0]  x0_n_ff [4];
   logic signed [NW-1:0]  x0_n_in [4];
   logic [TW-1:0]         x0_tail_ff;
   logic                  x0_v_ff;

   logic signed [NW-1:0]  x1_n_ff [4];
   logic signed [P1W-1:0] x1_p_ff [6];
   logic [TW-1:0]         x1_tail_ff;
   logic                  x1_v_ff;

   logic signed [NW-1:0]  x2_n_ff [4];
   logic signed [CW-1:0]  x2_c1_ff [3];
   logic signed [CW-1:0]  x2_c1_in [3];
   logic [TW-1:0]         x2_tail_ff;
   logic                  x2_v_ff;

   logic signed [P2W-1:0] x3_m_ff [9];
   logic [TW-1:0]         x3_tail_ff;
   logic                  x3_v_ff;

   logic signed [ACW-1:0] x4_acc_ff [3];
   logic signed [ACW-1:0] x4_acc_in [3];
   logic [TW-1:0]         x4_tail_ff;
   logic                  x4_v_ff;

   logic [3*VW-1:0]       rot_ff, rot_in;
   logic                  status_ff, sat_ff, sat_in;

   logic signed [VW-1:0]  vx, vy, vz;
   logic signed [P1W:0]   t [3];
   logic signed [P1W:0]   th;
   logic signed [ACW-1:0] ah, ash;
   logic signed [RDW-1:0] rsum;
   logic signed [VW-1:0]  vc;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         x0_n_in[j] = dv_tail_ff[DS-1][3*VW+j] ? -signed'({1'b0, dv_q_ff[DS-1][j]})
                                                : signed'({1'b0, dv_q_ff[DS-1][j]});
      end
   end

   assign vx = signed'(x0_tail_ff[0 +: VW]);
   assign vy = signed'(x0_tail_ff[VW +: VW]);
   assign vz = signed'(x0_tail_ff[2*VW +: VW]);

   // n x v, rounded back to vector units
   always_comb begin
      t[0] = (P1W + 1)'(x1_p_ff[0]) - (P1W + 1)'(x1_p_ff[1]);
      t[1] = (P1W + 1)'(x1_p_ff[2]) - (P1W + 1)'(x1_p_ff[3]);
      t[2] = (P1W + 1)'(x1_p_ff[4]) - (P1W + 1)'(x1_p_ff[5]);
      th = '0;
      for (int i = 0; i < 3; i++) begin
         th = t[i] + HALF1;
         x2_c1_in[i] = CW'(th >>> NF);
      end
   end

   always_comb begin
      x4_acc_in[0] = ACW'(x3_m_ff[6]) + ACW'(x3_m_ff[0]) - ACW'(x3_m_ff[1]);
      x4_acc_in[1] = ACW'(x3_m_ff[7]) + ACW'(x3_m_ff[2]) - ACW'(x3_m_ff[3]);
      x4_acc_in[2] = ACW'(x3_m_ff[8]) + ACW'(x3_m_ff[4]) - ACW'(x3_m_ff[5]);
   end

   always_comb begin
      rot_in = '0;
      sat_in = 1'b0;
      ah = '0;
      ash = '0;
      rsum = '0;
      vc = '0;
      for (int i = 0; i < 3; i++) begin
         ah = x4_acc_ff[i] + HALF2;
         ash = ah >>> (NF - 1);
         vc = signed'(x4_tail_ff[i*VW +: VW]);
         rsum = RDW'(vc) + RDW'(ash);
         if (rsum > VMAX) begin
            rot_in[i*VW +: VW] = VMAX[VW-1:0];
            sat_in = 1'b1;
         end else if (rsum < VMIN) begin
            rot_in[i*VW +: VW] = VMIN[VW-1:0];
            sat_in = 1'b1;
         end else begin
            rot_in[i*VW +: VW] = rsum[VW-1:0];
         end
      end
      // singular quaternion gives a zero vector
      if (x4_tail_ff[TW-1]) begin
         rot_in = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x0_v_ff <= 1'b0;
         x1_v_ff <= 1'b0;
         x2_v_ff <= 1'b0;
         x3_v_ff <= 1'b0;
         x4_v_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         x0_v_ff <= dv_v_ff[DS-1];
         x1_v_ff <= x0_v_ff;
         x2_v_ff <= x1_v_ff;
         x3_v_ff <= x2_v_ff;
         x4_v_ff <= x3_v_ff;
         out_valid_ff <= x4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_tail_ff <= dv_tail_ff[DS-1];
         x1_tail_ff <= x0_tail_ff;
         x2_tail_ff <= x1_tail_ff;
         x3_tail_ff <= x2_tail_ff;
         x4_tail_ff <= x3_tail_ff;
         for (int j = 0; j < 4; j++) begin
            x0_n_ff[j] <= x0_n_in[j];
            x1_n_ff[j] <= x0_n_ff[j];
            x2_n_ff[j] <= x1_n_ff[j];
         end
         x1_p_ff[0] <= x0_n_ff[2] * vz;
         x1_p_ff[1] <= x0_n_ff[3] * vy;
         x1_p_ff[2] <= x0_n_ff[3] * vx;
         x1_p_ff[3] <= x0_n_ff[1] * vz;
         x1_p_ff[4] <= x0_n_ff[1] * vy;
         x1_p_ff[5] <= x0_n_ff[2] * vx;
         for (int i = 0; i < 3; i++) begin
            x2_c1_ff[i] <= x2_c1_in[i];
            x3_m_ff[6+i] <= x2_n_ff[0] * x2_c1_ff[i];
            x4_acc_ff[i] <= x4_acc_in[i];
         end
         x3_m_ff[0] <= x2_n_ff[2] * x2_c1_ff[2];
         x3_m_ff[1] <= x2_n_ff[3] * x2_c1_ff[1];
         x3_m_ff[2] <= x2_n_ff[3] * x2_c1_ff[0];
         x3_m_ff[3] <= x2_n_ff[1] * x2_c1_ff[2];
         x3_m_ff[4] <= x2_n_ff[1] * x2_c1_ff[1];
         x3_m_ff[5] <= x2_n_ff[2] * x2_c1_ff[0];
         rot_ff <= rot_in;
         sat_ff <= sat_in;
         status_ff <= x4_tail_ff[TW-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rot = rot_ff;
   assign out_status = status_ff;
   assign out_saturated = sat_ff;

endmodule

### hw/rtl/quaternion_rotate_vector.sv
// channel   dir  handshake              contents
// req       in   req_tvalid/tready      tdata: quat_w,x,y,z, vec_x,y,z
// rsp       out  rsp_tvalid/tready      tdata: rot_x,y,z; tuser: status, saturated
// csr       in   psel/penable/pready    min_norm_squared at byte address 0
//
// one request per cycle sustained while the queue is not full; each request is
// pipelined through a four-stage front end, a four-entry queue, a square root of
// 31 stages, four dividers of nfrac+1 stages and six rotation stages.
// reset clears the threshold, the queue and all stage valids.
// the front stalls only when the queue is full, the back only on rsp_tready.
module quaternion_rotate_vector #(
   parameter int QUAT_WIDTH = 16,
   parameter int VEC_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, zero fill
   input  logic [((4*QUAT_WIDTH+3*VEC_WIDTH+7)/8)*8-1:0] req_tdata,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rot_x, rot_y, rot_z, zero fill
   output logic [((3*VEC_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // status, saturated
   output logic [1:0] rsp_tuser,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [qrot_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int IN_W = 4 * QUAT_WIDTH + 3 * VEC_WIDTH;
   localparam int OUT_PAD = ((3 * VEC_WIDTH + 7) / 8) * 8 - 3 * VEC_WIDTH;
   localparam int ENTRY_W = 3 * VEC_WIDTH + 5 + 4 * qrot_pkg::A_W + qrot_pkg::S2_W;
   localparam int CFGW = qrot_pkg::CFG_W;

   logic [CFGW-1:0] min_norm_ff;
   logic            csr_write;
   logic            csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit = (32'(csr_paddr >> 2) == 32'(qrot_pkg::CSR_MIN_NORM_SQUARED));
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? 32'(min_norm_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_norm_ff <= '0;
      end else if (csr_write && csr_hit) begin
         min_norm_ff <= csr_pwdata[CFGW-1:0];
      end
   end

   logic                  front_valid;
   logic [ENTRY_W-1:0]    front_entry;
   logic [ENTRY_W-1:0]    queue_data;
   logic                  queue_pop;
   logic                  queue_push;
   qrot_pkg::qstat_type   queue_status;
   logic [3*VEC_WIDTH-1:0] rot;
   logic                  rot_status;
   logic                  rot_sat;

   assign req_tready = !queue_status.full;
   assign queue_push = front_valid && req_tready;

   qrot_front #(
      .QUAT_WIDTH(QUAT_WIDTH),
      .VEC_WIDTH(VEC_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .enable(req_tready),
      .in_valid(req_tvalid),
      .in_data(req_tdata[IN_W-1:0]),
      .min_norm(min_norm_ff),
      .out_valid(front_valid),
      .out_entry(front_entry)
   );

   qrot_queue #(
      .WIDTH(ENTRY_W)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(queue_push),
      .push_data(front_entry),
      .pop(queue_pop),
      .pop_data(queue_data),
      .status(queue_status)
   );

   qrot_back #(
      .VEC_WIDTH(VEC_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(!queue_status.empty),
      .in_entry(queue_data),
      .pop(queue_pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_rot(rot),
      .out_status(rot_status),
      .out_saturated(rot_sat)
   );

   if (OUT_PAD > 0) begin : g_pad
      assign rsp_tdata = {{OUT_PAD{1'b0}}, rot};
   end else begin : g_nopad
      assign rsp_tdata = rot;
   end
   assign rsp_tuser = {rot_sat, rot_status};

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("singular result carries data");

   a_csr_write : assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_hit |=> min_norm_ff == $past(csr_pwdata[CFGW-1:0]))
      else $error("threshold write lost");

   a_queue_state : assert property (@(posedge clock) disable iff (reset)
      !(queue_status.full && queue_status.empty))
      else $error("queue full and empty at once");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      queue_status.empty |-> !queue_pop)
      else $error("pop from empty queue");

endmodule
